/* hdl/pidsc_pkg.sv */
// Shared types and constants for the PID step unit with integral clamp.
// No dependencies; used by the register, front, queue, back and top-level files.
package pidsc_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  localparam logic [2:0] REG_TARGET = 3'd0;
  localparam logic [2:0] REG_GAIN_P = 3'd1;
  localparam logic [2:0] REG_GAIN_I = 3'd2;
  localparam logic [2:0] REG_GAIN_D = 3'd3;
  localparam logic [2:0] REG_LIMIT  = 3'd4;

  localparam logic signed [15:0] TARGET_RESET = 16'sd240;
  localparam logic signed [15:0] GAIN_P_RESET = 16'sd1;
  localparam logic signed [15:0] GAIN_I_RESET = 16'sd0;
  localparam logic signed [15:0] GAIN_D_RESET = 16'sd0;
  localparam logic [15:0]        LIMIT_RESET  = 16'd1000;

  typedef struct packed {
    logic signed [15:0] target;
    logic signed [15:0] gain_p;
    logic signed [15:0] gain_i;
    logic signed [15:0] gain_d;
    logic [15:0]        integral_limit;
  } cfg_t;

  // One classified sample handed from front to back.
  typedef struct packed {
    logic signed [16:0] err;
    logic signed [17:0] integ;
    logic signed [18:0] diff;
  } work_t;

endpackage

/* hdl/pidsc_meas_if.sv */
// Measurement channel: valid/ready handshake carrying one measurement.
// Depends on nothing.
interface pidsc_meas_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] measurement;

  modport source(output valid, measurement, input ready);
  modport sink(input valid, measurement, output ready);
endinterface

/* hdl/pidsc_result_if.sv */
// Result channel: valid/ready handshake carrying drive and error_now.
// Depends on nothing.
interface pidsc_result_if;
  logic               valid;
  logic               ready;
  logic signed [35:0] drive;
  logic signed [16:0] error_now;

  modport source(output valid, drive, error_now, input ready);
  modport sink(input valid, drive, error_now, output ready);
endinterface

/* hdl/pidsc_regs.sv */
// APB-style configuration register file for the PID unit.
// Depends on pidsc_pkg.
module pidsc_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pidsc_pkg::ADDR_W-1:0]  paddr,
  input  logic [pidsc_pkg::DATA_W-1:0]  pwdata,
  output logic [pidsc_pkg::DATA_W-1:0]  prdata,
  output logic                          pready,
  output pidsc_pkg::cfg_t               cfg
);

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[4:2];
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target         <= pidsc_pkg::TARGET_RESET;
      cfg.gain_p         <= pidsc_pkg::GAIN_P_RESET;
      cfg.gain_i         <= pidsc_pkg::GAIN_I_RESET;
      cfg.gain_d         <= pidsc_pkg::GAIN_D_RESET;
      cfg.integral_limit <= pidsc_pkg::LIMIT_RESET;
    end else if (wr) begin
      unique case (idx)
        pidsc_pkg::REG_TARGET: cfg.target         <= pwdata[15:0];
        pidsc_pkg::REG_GAIN_P: cfg.gain_p         <= pwdata[15:0];
        pidsc_pkg::REG_GAIN_I: cfg.gain_i         <= pwdata[15:0];
        pidsc_pkg::REG_GAIN_D: cfg.gain_d         <= pwdata[15:0];
        pidsc_pkg::REG_LIMIT:  cfg.integral_limit <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      pidsc_pkg::REG_TARGET: prdata = {{16{cfg.target[15]}}, cfg.target};
      pidsc_pkg::REG_GAIN_P: prdata = {{16{cfg.gain_p[15]}}, cfg.gain_p};
      pidsc_pkg::REG_GAIN_I: prdata = {{16{cfg.gain_i[15]}}, cfg.gain_i};
      pidsc_pkg::REG_GAIN_D: prdata = {{16{cfg.gain_d[15]}}, cfg.gain_d};
      pidsc_pkg::REG_LIMIT:  prdata = {16'd0, cfg.integral_limit};
      default:               prdata = '0;
    endcase
  end

endmodule

/* hdl/pidsc_front.sv */
// Front end: accepts measurements, forms error, clamped integral and difference.
// Holds integral and last error state. Depends on pidsc_pkg, pidsc_meas_if.
module pidsc_front (
  input  logic                 clk,
  input  logic                 rst,
  input  pidsc_pkg::cfg_t      cfg,
  pidsc_meas_if.sink           meas,
  input  logic                 q_full,
  output logic                 push,
  output pidsc_pkg::work_t     push_data
);

  logic signed [17:0] integral_sum;
  logic signed [16:0] last_error;
  logic signed [16:0] err;
  logic signed [18:0] acc_raw;
  logic signed [18:0] lim;
  logic signed [18:0] acc_clamp;

  assign meas.ready = !q_full;
  assign push       = meas.valid && !q_full;

  assign err     = 17'(cfg.target) - 17'(meas.measurement);
  assign acc_raw = 19'(integral_sum) + 19'(err);
  assign lim     = $signed({3'b000, cfg.integral_limit});

  always_comb begin
    priority if (acc_raw > lim) begin
      acc_clamp = lim;
    end else if (acc_raw < -lim) begin
      acc_clamp = -lim;
    end else begin
      acc_clamp = acc_raw;
    end
  end

  assign push_data.err   = err;
  assign push_data.integ = acc_clamp[17:0];
  assign push_data.diff  = 19'(err) - 19'(last_error);

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum <= '0;
      last_error   <= '0;
    end else if (push) begin
      integral_sum <= acc_clamp[17:0];
      last_error   <= err;
    end
  end

endmodule

/* hdl/pidsc_queue.sv */
// Small FIFO of classified samples between front and back.
// Depends on pidsc_pkg.
module pidsc_queue #(
  parameter int unsigned DEPTH = pidsc_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  pidsc_pkg::work_t push_data,
  input  logic             pop,
  output pidsc_pkg::work_t pop_data,
  output logic             full,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  pidsc_pkg::work_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* hdl/pidsc_back.sv */
// Back end: multiplies the P, I and D terms, then sums them into the output register.
// Depends on pidsc_pkg, pidsc_result_if.
module pidsc_back (
  input  logic             clk,
  input  logic             rst,
  input  pidsc_pkg::cfg_t  cfg,
  input  logic             q_empty,
  input  pidsc_pkg::work_t q_data,
  output logic             pop,
  pidsc_result_if.source   res
);

  logic               s1_valid;
  logic signed [32:0] p_term;
  logic signed [33:0] i_term;
  logic signed [34:0] d_term;
  logic signed [16:0] s1_err;
  logic               out_valid;
  logic signed [35:0] drive;
  logic signed [16:0] error_now;
  logic               adv_out;
  logic               adv_s1;

  assign adv_out = !out_valid || res.ready;
  assign adv_s1  = !s1_valid || adv_out;
  assign pop     = adv_s1 && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv_s1) begin
        s1_valid <= !q_empty;
      end
      if (adv_out) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      p_term <= 33'(cfg.gain_p) * 33'(q_data.err);
      i_term <= 34'(cfg.gain_i) * 34'(q_data.integ);
      d_term <= 35'(cfg.gain_d) * 35'(q_data.diff);
      s1_err <= q_data.err;
    end
    if (adv_out && s1_valid) begin
      drive     <= 36'(p_term) + 36'(i_term) + 36'(d_term);
      error_now <= s1_err;
    end
  end

  assign res.valid     = out_valid;
  assign res.drive     = drive;
  assign res.error_now = error_now;

endmodule

/* hdl/pid_step_with_integral_clamp_unit.sv */
// PID step with integral clamp: one drive value per measurement transaction.
// Throughput: one transaction per cycle, while the queue is not full.
// Result path: the sample is registered in the queue, then the multiply stage, then the sum stage.
// Queue of QUEUE_DEPTH entries decouples front and back; back stalls only on res.ready.
// Synchronous active-high reset: integral and last error cleared, registers to defaults.
module pid_step_with_integral_clamp_unit #(
  parameter int unsigned QUEUE_DEPTH = pidsc_pkg::QUEUE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  pidsc_meas_if.sink                   meas,
  pidsc_result_if.source               res,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pidsc_pkg::ADDR_W-1:0] paddr,
  input  logic [pidsc_pkg::DATA_W-1:0] pwdata,
  output logic [pidsc_pkg::DATA_W-1:0] prdata,
  output logic                         pready
);

  pidsc_pkg::cfg_t  cfg;
  pidsc_pkg::work_t push_data;
  pidsc_pkg::work_t pop_data;
  logic             push;
  logic             pop;
  logic             q_full;
  logic             q_empty;

  pidsc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pidsc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .meas      (meas),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  pidsc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  pidsc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_data  (pop_data),
    .pop     (pop),
    .res     (res)
  );

endmodule
